// ===== rtl/unsorted_key_value_table_defines.svh =====
// assertion macros used by the table controller rtl
`ifndef UNSORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define UNSORTED_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define UKVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define UKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UKVT_ASSERT(lbl, prop, msg)
`define UKVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ukvt_pkg.sv =====
package ukvt_pkg;

	localparam int unsigned DEPTH_DEF       = 64;
	localparam int unsigned KEY_WIDTH_DEF   = 32;
	localparam int unsigned VALUE_WIDTH_DEF = 64;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned CAP_W   = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
	localparam logic [OP_W-1:0] OP_UPSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;
	localparam logic [OP_W-1:0] OP_GET_AT = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [KEY_W-1:0]   key_out;
		logic [VALUE_W-1:0] value_out;
		logic [COUNT_W-1:0] count;
	} rsp_t;

endpackage

// ===== rtl/ukvt_mem.sv =====
module ukvt_mem #(
	parameter int unsigned DEPTH       = ukvt_pkg::DEPTH_DEF,
	parameter int unsigned KEY_WIDTH   = ukvt_pkg::KEY_WIDTH_DEF,
	parameter int unsigned VALUE_WIDTH = ukvt_pkg::VALUE_WIDTH_DEF,
	parameter int unsigned AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  logic [KEY_WIDTH-1:0]   wr_key,
	input  logic [VALUE_WIDTH-1:0] wr_val,
	input  logic [AW-1:0]          rd_addr,
	output logic [KEY_WIDTH-1:0]   rd_key,
	output logic [VALUE_WIDTH-1:0] rd_val
);
	import ukvt_pkg::*;

	logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
	logic [KEY_WIDTH-1:0]   rd_key_q;
	logic [VALUE_WIDTH-1:0] rd_val_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	assign rd_key = rd_key_q;
	assign rd_val = rd_val_q;

endmodule

// ===== rtl/ukvt_ctrl.sv =====
`include "unsorted_key_value_table_defines.svh"

module ukvt_ctrl #(
	parameter int unsigned DEPTH       = ukvt_pkg::DEPTH_DEF,
	parameter int unsigned KEY_WIDTH   = ukvt_pkg::KEY_WIDTH_DEF,
	parameter int unsigned VALUE_WIDTH = ukvt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ukvt_pkg::CAP_W-1:0]  capacity,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  ukvt_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output ukvt_pkg::rsp_t              rsp
);
	import ukvt_pkg::*;

	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SEARCH   = 3'd1;
	localparam logic [2:0] ST_MOVE_RD  = 3'd2;
	localparam logic [2:0] ST_MOVE_WR  = 3'd3;
	localparam logic [2:0] ST_APPEND   = 3'd4;
	localparam logic [2:0] ST_IDX_RD   = 3'd5;
	localparam logic [2:0] ST_IDX_DATA = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       ptr_q;
	logic                   cmp_vld_s1;
	logic [AW-1:0]          cmp_ptr_s1;
	logic [AW-1:0]          pos_q;
	logic [AW-1:0]          app_addr_q;
	logic [AW-1:0]          idx_q;
	logic                   grow_q;
	logic [OP_W-1:0]        op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic                   res_ok_q;
	logic [KEY_W-1:0]       res_key_q;
	logic [VALUE_W-1:0]     res_val_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   accept;
	logic                   idx_ok;
	logic                   ptr_lt;
	logic                   hit;
	logic                   miss;
	logic                   issue;
	logic                   full;
	logic                   can_add;
	logic                   load_rsp;
	logic [CNT_W-1:0]       last;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [KEY_WIDTH-1:0]   wr_key;
	logic [VALUE_WIDTH-1:0] wr_val;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;

	ukvt_mem #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.AW          (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_val  (wr_val),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_val  (rd_val)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign idx_ok    = int'(req.index) < int'(cnt_q);
	assign ptr_lt    = ptr_q < cnt_q;
	assign hit       = (state_q == ST_SEARCH) && cmp_vld_s1 && (rd_key == key_q);
	// scan done once nothing is in flight and every entry was issued
	assign miss      = (state_q == ST_SEARCH) && !cmp_vld_s1 && !ptr_lt;
	assign issue     = (state_q == ST_SEARCH) && !hit && ptr_lt;
	assign full      = int'(cnt_q) >= ((int'(capacity) > int'(DEPTH)) ? int'(DEPTH)
	                                                                : int'(capacity));
	assign can_add   = (op_q == OP_INSERT || op_q == OP_UPSERT) && !full;
	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign last      = cnt_q - CNT_W'(1);

	always_comb begin
		case (state_q)
			ST_SEARCH: rd_addr = ptr_q[AW-1:0];
			ST_MOVE_RD: rd_addr = last[AW-1:0];
			ST_IDX_RD: rd_addr = idx_q;
			default: rd_addr = ptr_q[AW-1:0];
		endcase
	end

	// on erase or update the last entry fills the hole; an update or add then writes the new pair to the tail
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = app_addr_q;
		wr_key  = key_q;
		wr_val  = val_q;
		case (state_q)
			ST_MOVE_WR: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_key  = rd_key;
				wr_val  = rd_val;
			end
			ST_APPEND: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			ptr_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					if (accept) begin
						case (req.op)
							OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP: begin
								state_q <= ST_SEARCH;
							end
							OP_GET_AT: begin
								state_q <= idx_ok ? ST_IDX_RD : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						if (op_q == OP_LOOKUP || op_q == OP_INSERT) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MOVE_RD;
						end
					end else if (miss) begin
						state_q <= can_add ? ST_APPEND : ST_DONE;
					end else if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
				end
				ST_MOVE_RD: begin
					state_q <= ST_MOVE_WR;
				end
				ST_MOVE_WR: begin
					if (op_q == OP_ERASE) begin
						cnt_q   <= last;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (grow_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_IDX_RD: begin
					state_q <= ST_IDX_DATA;
				end
				ST_IDX_DATA: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q      <= req.op;
					key_q     <= KEY_WIDTH'(req.key);
					val_q     <= VALUE_WIDTH'(req.value);
					idx_q     <= AW'(req.index);
					res_ok_q  <= 1'b0;
					res_val_q <= '0;
					grow_q    <= 1'b0;
					if (req.op == OP_GET_AT) begin
						res_key_q <= '0;
					end else begin
						res_key_q <= KEY_W'(KEY_WIDTH'(req.key));
					end
				end
			end
			ST_SEARCH: begin
				cmp_ptr_s1 <= ptr_q[AW-1:0];
				if (hit) begin
					pos_q      <= cmp_ptr_s1;
					app_addr_q <= last[AW-1:0];
					grow_q     <= 1'b0;
					if (op_q == OP_LOOKUP) begin
						res_ok_q  <= 1'b1;
						res_val_q <= VALUE_W'(rd_val);
					end
				end else if (miss && can_add) begin
					res_ok_q   <= 1'b1;
					app_addr_q <= cnt_q[AW-1:0];
					grow_q     <= 1'b1;
				end
			end
			ST_MOVE_WR: begin
				if (op_q inside {OP_ERASE, OP_UPDATE, OP_UPSERT}) begin
					res_ok_q <= 1'b1;
				end
			end
			ST_IDX_DATA: begin
				res_ok_q  <= 1'b1;
				res_key_q <= KEY_W'(rd_key);
				res_val_q <= VALUE_W'(rd_val);
			end
			ST_DONE: begin
				if (load_rsp) begin
					rsp_q.ok        <= res_ok_q;
					rsp_q.key_out   <= res_key_q;
					rsp_q.value_out <= res_val_q;
					rsp_q.count     <= COUNT_W'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	// output register lets the next request start while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`UKVT_ASSERT(a_cnt_bound, int'(cnt_q) <= int'(DEPTH), "entry count beyond depth")
	`UKVT_ASSERT(a_hit_in_range, !hit || (int'(cmp_ptr_s1) < int'(cnt_q)), "hit past last entry")
	`UKVT_ASSERT(a_wr_in_range, !wr_en || (int'(wr_addr) <= int'(cnt_q)), "write past tail")
	`UKVT_ASSERT(a_cnt_change, $stable(cnt_q) || $past(state_q) == ST_APPEND || $past(state_q) == ST_MOVE_WR, "count changed outside a write step")
	`UKVT_ASSERT_NEXT(a_lookup_hit, hit && op_q == OP_LOOKUP, state_q == ST_DONE && res_ok_q, "lookup hit not reported")

endmodule

// ===== rtl/unsorted_key_value_table.sv =====
// Bounded key/value table held unsorted and packed at the front of one single-port-read
// synchronous memory. Requests are handled one at a time; a result sits in an output
// register, so the next request is taken while it waits. Insert, update, insert-or-update,
// erase and lookup scan the stored keys one per cycle through the memory read port; the
// scan stops at the first match or after the last stored key. Get-at-index reads the pair
// at the index directly, or fails at once when the index is past the last pair. The user
// must write the capacity register only while the table is idle; the block itself does
// not enforce it.
module unsorted_key_value_table #(
	parameter int unsigned DEPTH       = ukvt_pkg::DEPTH_DEF,
	parameter int unsigned KEY_WIDTH   = ukvt_pkg::KEY_WIDTH_DEF,
	parameter int unsigned VALUE_WIDTH = ukvt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ukvt_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  ukvt_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output ukvt_pkg::rsp_t             rsp
);
	import ukvt_pkg::*;

	logic [CAP_W-1:0] capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	ukvt_ctrl #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import ukvt_pkg::*;

	localparam int unsigned TABLE_DEPTH = DEPTH_DEF;
	// op codes the block does not define
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
	localparam int SETTLE_CYCLES = 80;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 1025;
	localparam int N_PHASES = 10;
	localparam int POOL_SIZE = 128;
	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int POOL_W = $clog2(POOL_SIZE);
	localparam int PHASE_W = $clog2(N_PHASES);

	typedef struct {
		req_t r;
		bit   fixed;
		rsp_t want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;

	// shadow copy of the table and its capacity register
	logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
	logic [VALUE_W-1:0] shadow_vals [TABLE_DEPTH];
	int unsigned        fill_count;
	logic [CAP_W-1:0]   cap_shadow;

	rsp_t             expected_rsps [$];
	dir_row_t         dir_rows [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int mismatches = 0;
	int results_seen = 0;
	int ok_seen = 0;
	int peak_fill = 0;
	int items_sent = 0;
	bit req_gaps = 1'b1;
	bit rsp_gaps = 1'b1;
	bit hold_off_pending = 1'b0;

	unsorted_key_value_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void drop_slot(input int pos);
		shadow_keys[SLOT_W'(pos)] = shadow_keys[SLOT_W'(fill_count - 1)];
		shadow_vals[SLOT_W'(pos)] = shadow_vals[SLOT_W'(fill_count - 1)];
		fill_count--;
	endfunction

	function automatic void place_last(input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v);
		shadow_keys[SLOT_W'(fill_count)] = k;
		shadow_vals[SLOT_W'(fill_count)] = v;
		fill_count++;
	endfunction

	function automatic bit try_insert(input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v,
			input int pos);
		int unsigned lim;
		lim = (cap_shadow > TABLE_DEPTH) ? TABLE_DEPTH : cap_shadow;
		if (pos >= 0 || fill_count >= lim)
			return 1'b0;
		place_last(k, v);
		return 1'b1;
	endfunction

	// update frees the old slot first, so it never fails for lack of room
	function automatic bit try_update(input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v,
			input int pos);
		if (pos < 0)
			return 1'b0;
		drop_slot(pos);
		place_last(k, v);
		return 1'b1;
	endfunction

	function automatic rsp_t table_apply(input req_t r);
		rsp_t o;
		int pos;
		int i;
		pos = -1;
		for (i = 0; i < fill_count; i++)
			if (pos < 0 && shadow_keys[SLOT_W'(i)] == r.key)
				pos = i;
		o.ok = 1'b0;
		o.key_out = r.key;
		o.value_out = '0;
		case (r.op)
			OP_INSERT: o.ok = try_insert(r.key, r.value, pos);
			OP_UPDATE: o.ok = try_update(r.key, r.value, pos);
			OP_UPSERT: begin
				o.ok = (pos >= 0) ? try_update(r.key, r.value, pos)
					: try_insert(r.key, r.value, pos);
			end
			OP_ERASE: begin
				if (pos >= 0) begin
					drop_slot(pos);
					o.ok = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (pos >= 0) begin
					o.value_out = shadow_vals[SLOT_W'(pos)];
					o.ok = 1'b1;
				end
			end
			OP_GET_AT: begin
				o.key_out = '0;
				if (r.index < fill_count) begin
					o.key_out = shadow_keys[r.index];
					o.value_out = shadow_vals[r.index];
					o.ok = 1'b1;
				end
			end
			default: ;
		endcase
		o.count = COUNT_W'(fill_count);
		return o;
	endfunction

	// mostly keys already held or from a small pool, so hits and collisions are common
	function automatic req_t random_req(input int ins_weight);
		req_t r;
		int roll;
		int pick;
		int hit_pct;
		roll = $urandom_range(0, 99);
		if (roll >= 97)
			r.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
		else if (roll < ins_weight)
			r.op = ($urandom_range(0, 2) == 0) ? OP_UPSERT : OP_INSERT;
		else begin
			case ($urandom_range(0, 3))
				0: r.op = OP_UPDATE;
				1: r.op = OP_ERASE;
				2: r.op = OP_LOOKUP;
				default: r.op = OP_GET_AT;
			endcase
		end
		hit_pct = (r.op == OP_INSERT || r.op == OP_UPSERT) ? 20 : 60;
		pick = $urandom_range(0, 99);
		if (fill_count > 0 && pick < hit_pct)
			r.key = shadow_keys[SLOT_W'($urandom_range(0, fill_count - 1))];
		else if (pick < 85)
			r.key = key_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
		else
			r.key = $urandom;
		r.value = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0)
			r.index = INDEX_W'($urandom_range(0,
				(fill_count < TABLE_DEPTH) ? fill_count : TABLE_DEPTH - 1));
		else
			r.index = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
		return r;
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v, input logic [INDEX_W-1:0] idx, input bit fixed,
			input logic ok, input logic [KEY_W-1:0] ko, input logic [VALUE_W-1:0] vo,
			input logic [COUNT_W-1:0] c);
		dir_row_t row;
		row.r.op = op;
		row.r.key = k;
		row.r.value = v;
		row.r.index = idx;
		row.fixed = fixed;
		row.want.ok = ok;
		row.want.key_out = ko;
		row.want.value_out = vo;
		row.want.count = c;
		dir_rows.push_back(row);
	endfunction

	// holds the transfer until accepted, then predicts it and draws the gap to the next one
	task automatic send_req(input req_t r, input bit fixed, input rsp_t fixed_rsp);
		rsp_t pred;
		int gap;
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pred = table_apply(r);
		expected_rsps.push_back(fixed ? fixed_rsp : pred);
		items_sent++;
		if (fill_count > peak_fill)
			peak_fill = fill_count;
		gap = req_gaps ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_table();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : receiver
		int w;
		rsp_stall = 1'b0;
		forever begin
			w = rsp_gaps ? $urandom_range(0, 14) : 0;
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				w = LONG_HOLD;
			end
			if (w > 0) begin
				rsp_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (expected_rsps.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, key_out %h", rsp.key_out));
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.ok !== want.ok)
					report_mismatch($sformatf("ok got %b want %b", rsp.ok, want.ok));
				if (rsp.key_out !== want.key_out)
					report_mismatch($sformatf("key_out got %h want %h", rsp.key_out, want.key_out));
				if (rsp.value_out !== want.value_out)
					report_mismatch($sformatf("value_out got %h want %h",
						rsp.value_out, want.value_out));
				if (rsp.count !== want.count)
					report_mismatch($sformatf("count got %0d want %0d", rsp.count, want.count));
				if (rsp.ok === 1'b1)
					ok_seen++;
			end
		end
	end

	initial begin : stimulus
		logic [CAP_W-1:0] caps [N_PHASES];
		int ins_w [N_PHASES];
		int per_phase;
		int p;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		fill_count = 0;
		cap_shadow = CAP_RESET;
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = KEY_MAX;
		caps = '{7'd127, 7'd0, 7'd64, 7'd3, 7'd1, 7'd40, 7'd64, 7'd90, 7'd10, 7'd64};
		ins_w = '{85, 10, 70, 25, 40, 55, 75, 60, 35, 50};
		caps[7] = CAP_W'($urandom_range(0, 127));

		// empty table, reset capacity
		add_row(OP_GET_AT, '0, '0, 6'd0, 1'b1, 1'b0, '0, '0, 7'd0);
		add_row(OP_LOOKUP, '0, '0, 6'd0, 1'b1, 1'b0, '0, '0, 7'd0);
		add_row(OP_ERASE, KEY_MAX, '0, 6'd0, 1'b1, 1'b0, KEY_MAX, '0, 7'd0);
		add_row(OP_UPDATE, 32'd5, VALUE_MAX, 6'd0, 1'b1, 1'b0, 32'd5, '0, 7'd0);
		add_row(OP_INSERT, '0, '0, 6'd0, 1'b1, 1'b1, '0, '0, 7'd1);
		add_row(OP_INSERT, KEY_MAX, VALUE_MAX, 6'd63, 1'b1, 1'b1, KEY_MAX, '0, 7'd2);
		add_row(OP_INSERT, '0, 64'h123, 6'd0, 1'b1, 1'b0, '0, '0, 7'd2);
		add_row(OP_GET_AT, '0, '0, 6'd1, 1'b1, 1'b1, KEY_MAX, VALUE_MAX, 7'd2);
		add_row(OP_GET_AT, KEY_MAX, '0, 6'd2, 1'b1, 1'b0, '0, '0, 7'd2);
		add_row(OP_GET_AT, 32'h5a5a_a5a5, VALUE_MAX, 6'd63, 1'b1, 1'b0, '0, '0, 7'd2);
		add_row(OP_LOOKUP, KEY_MAX, '0, 6'd0, 1'b1, 1'b1, KEY_MAX, VALUE_MAX, 7'd2);
		// update moves the pair to the back
		add_row(OP_UPSERT, '0, 64'haaaa_aaaa_aaaa_aaaa, 6'd0, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_GET_AT, '0, '0, 6'd0, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_UPSERT, 32'h1234_5678, 64'h5555_5555_5555_5555, 6'd0, 1'b0,
			1'b0, '0, '0, 7'd0);
		add_row(OP_UPDATE, KEY_MAX, 64'h0123_4567_89ab_cdef, 6'd0, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_LOOKUP, '0, '0, 6'd0, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_SPARE_A, 32'hdead_beef, VALUE_MAX, 6'd63, 1'b1, 1'b0, 32'hdead_beef, '0, 7'd3);
		add_row(OP_SPARE_B, '0, '0, 6'd21, 1'b1, 1'b0, '0, '0, 7'd3);
		// erase pulls the last pair into the hole
		add_row(OP_ERASE, '0, '0, 6'd0, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_LOOKUP, '0, '0, 6'd0, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_GET_AT, '0, '0, 6'd1, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_ERASE, 32'h1234_5678, '0, 6'd0, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_ERASE, KEY_MAX, '0, 6'd0, 1'b0, 1'b0, '0, '0, 7'd0);
		add_row(OP_GET_AT, '0, '0, 6'd0, 1'b1, 1'b0, '0, '0, 7'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].want);

		per_phase = RANDOM_ITEMS / N_PHASES;
		for (p = 0; p < N_PHASES; p++) begin
			drain_table();
			cfg_we <= 1'b1;
			cfg_wdata <= caps[PHASE_W'(p)];
			@(posedge clk);
			cfg_we <= 1'b0;
			cap_shadow = caps[PHASE_W'(p)];
			req_gaps = ($urandom_range(0, 3) != 0);
			rsp_gaps = ($urandom_range(0, 3) != 0);
			// back-to-back requests while the output is held off fill the pipe
			if (p == 2)
				req_gaps = 1'b0;
			for (n = 0; n < per_phase; n++) begin
				if (p == 2 && n == 10)
					hold_off_pending = 1'b1;
				if (p == 5 && n == per_phase / 2)
					drain_table();
				send_req(random_req(ins_w[PHASE_W'(p)]), 1'b0, '0);
			end
		end
		drain_table();

		$display("ran %0d requests over %0d capacity settings, 0, 64 and 127 among them",
			items_sent, N_PHASES);
		$display("checked %0d results, %0d successful, table held up to %0d pairs",
			results_seen, ok_seen, peak_fill);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#12_000_000;
		$display("timeout with %0d results outstanding", expected_rsps.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
